/* rtl/core/gmt_pkg.sv */
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types, constants and helpers for the grid mesh triangulator.
// ----------------------------------------------------------------------------
package gmt_pkg;

    localparam int NUM_W      = 24;
    localparam int LIM_W      = 14;
    localparam int COLS_CFG_W = 13;
    localparam int ROWS_CFG_W = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [NUM_W-1:0]      NUM_MAX    = 24'hFF_FFFF;
    localparam logic [NUM_W-1:0]      NUM_FIRST  = 24'd1;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 13'd640;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 12'd480;
    localparam logic [LIM_W-1:0]      LIM_MIN    = 14'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        KIND_VERTEX = 1'b0,
        KIND_FACE   = 1'b1
    } record_kind_t;

    // Bit positions in a record mask
    localparam int REC_VERTEX = 0;
    localparam int REC_FACE_A = 1;
    localparam int REC_FACE_B = 2;
    localparam int REC_N      = 3;

    typedef logic [REC_N-1:0] rec_mask_t;

    // One pixel as handed from the scan logic to the record emitter
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] below;
        logic             has_up;
        logic             row_pos;
        logic             col_pos;
    } scan_item_t;

    function automatic logic [LIM_W-1:0] clamp_lim(
        input logic [LIM_W-1:0] v,
        input logic [LIM_W-1:0] hi
    );
        logic [LIM_W-1:0] res;
        if (v < LIM_MIN)
            res = LIM_MIN;
        else if (v > hi)
            res = hi;
        else
            res = v;
        return res;
    endfunction

endpackage

/* rtl/core/grid_mesh_triangulator.sv */
// ----------------------------------------------------------------------------
// grid_mesh_triangulator
// Streaming triangulation of an organised point grid scanned column by column.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / point_valid) carries one transaction
//   per grid pixel, rows inner, columns outer. Output channel (out_valid /
//   out_stall) carries vertex and face records; last marks the final record
//   of a pixel. A pixel with no vertex and no face produces no transaction.
//   A pixel is registered in the holding stage, and its records then pass
//   through the output register. Throughput: one pixel per cycle while each
//   pixel yields at most one record and out_stall is low; a pixel with two
//   or three records stalls input until they drain through the single output register.
//   The previous column's vertex numbers sit in a one-read, one-write line
//   store; each pixel writes its own row and prefetches the row above, which
//   also serves as the next pixel's left neighbour.
//   Reset: frame 640 x 480, scan at column 0 row 0, numbering from 1; the
//   line store needs no clearing since column 0 fills it before any read data is used.
//   Configuration writes restart the frame; issue them only while idle.
//   When the receiver stalls, hold the output record and stall the input
//   once the pending pixel cannot drain.
// ----------------------------------------------------------------------------
module grid_mesh_triangulator #(
    parameter int MAX_ROWS    = 2048,
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [gmt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           point_valid,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           record_kind,
    output logic [gmt_pkg::NUM_W-1:0]      first_vertex,
    output logic [gmt_pkg::NUM_W-1:0]      second_vertex,
    output logic [gmt_pkg::NUM_W-1:0]      third_vertex,
    output logic                           last
);
    import gmt_pkg::*;

    localparam int RA_W = $clog2(MAX_ROWS);

    logic             accept;
    logic             hold;
    scan_item_t       item;
    logic [RA_W-1:0]  wr_addr;
    logic [RA_W-1:0]  rd_addr;
    logic [NUM_W-1:0] rd_data;

    // Take a pixel whenever the emitter can free its holding stage
    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    gmt_scan #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .point_valid  (point_valid),
        .item         (item),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    // Write own row, read row above: never the same entry in one cycle
    gmt_line_store #(
        .DEPTH  (MAX_ROWS),
        .DATA_W (NUM_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (item.num),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gmt_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .item          (item),
        .rd_data       (rd_data),
        .hold          (hold),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .record_kind   (record_kind),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .third_vertex  (third_vertex),
        .last          (last)
    );

endmodule

/* rtl/core/gmt_line_store.sv */
// ----------------------------------------------------------------------------
// gmt_line_store
// Single-write, single-read line memory holding the previous column's vertex
// numbers; read data registered.
// ----------------------------------------------------------------------------
module gmt_line_store #(
    parameter  int DEPTH  = 2048,
    parameter  int DATA_W = 24,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/gmt_scan.sv */
// ----------------------------------------------------------------------------
// gmt_scan
// Scan position, vertex numbering, frame limits and line store addressing.
// ----------------------------------------------------------------------------
module gmt_scan #(
    parameter  int MAX_ROWS    = 2048,
    parameter  int MAX_COLUMNS = 4096,
    localparam int RA_W        = $clog2(MAX_ROWS),
    localparam int CA_W        = $clog2(MAX_COLUMNS)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [gmt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gmt_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                accept,
    input  logic                                point_valid,
    output gmt_pkg::scan_item_t                 item,
    output logic [RA_W-1:0]                     wr_addr,
    output logic [RA_W-1:0]                     rd_addr
);
    import gmt_pkg::*;

    localparam logic [LIM_W-1:0] ROWS_HI  = LIM_W'(MAX_ROWS);
    localparam logic [LIM_W-1:0] COLS_HI  = LIM_W'(MAX_COLUMNS);
    localparam logic [LIM_W-1:0] ROWS_RST = clamp_lim(LIM_W'(ROWS_RESET), ROWS_HI);
    localparam logic [LIM_W-1:0] COLS_RST = clamp_lim(LIM_W'(COLS_RESET), COLS_HI);

    logic [RA_W-1:0]  row_reg,      row_next;
    logic [CA_W-1:0]  col_reg,      col_next;
    logic [NUM_W-1:0] below_reg,    below_next;
    logic [NUM_W-1:0] next_num_reg, next_num_next;
    logic [LIM_W-1:0] rows_lim_reg, rows_lim_next;
    logic [LIM_W-1:0] cols_lim_reg, cols_lim_next;

    logic [LIM_W-1:0] row_inc;
    logic [LIM_W-1:0] col_inc;
    logic             last_row;
    logic             last_col;
    logic [NUM_W-1:0] num;

    always_comb
    begin
        row_inc  = LIM_W'(row_reg) + 1'b1;
        col_inc  = LIM_W'(col_reg) + 1'b1;
        last_row = (row_inc >= rows_lim_reg);
        last_col = (col_inc >= cols_lim_reg);
        num      = point_valid ? next_num_reg : '0;

        item.num     = num;
        item.below   = below_reg;
        item.has_up  = !last_row;
        item.row_pos = (row_reg != '0);
        item.col_pos = (col_reg != '0);

        wr_addr = row_reg;
        // Prefetch the upper neighbour; on the last row fetch row 0 for the next column
        rd_addr = last_row ? '0 : RA_W'(row_inc);
    end

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        below_next    = below_reg;
        next_num_next = next_num_reg;
        rows_lim_next = rows_lim_reg;
        cols_lim_next = cols_lim_reg;

        if (cfg_write_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COLUMNS:
                begin
                    cols_lim_next = clamp_lim(LIM_W'(cfg_data[COLS_CFG_W-1:0]), COLS_HI);
                    row_next      = '0;
                    col_next      = '0;
                    below_next    = '0;
                    next_num_next = NUM_FIRST;
                end
                REG_ROWS:
                begin
                    rows_lim_next = clamp_lim(LIM_W'(cfg_data[ROWS_CFG_W-1:0]), ROWS_HI);
                    row_next      = '0;
                    col_next      = '0;
                    below_next    = '0;
                    next_num_next = NUM_FIRST;
                end
                default:
                begin
                end
            endcase
        end
        else if (accept)
        begin
            below_next = num;
            if (point_valid && (next_num_reg != NUM_MAX))
            begin
                next_num_next = next_num_reg + 1'b1;
            end
            if (last_row)
            begin
                row_next = '0;
                if (last_col)
                begin
                    // End of frame: restart the scan and the numbering
                    col_next      = '0;
                    below_next    = '0;
                    next_num_next = NUM_FIRST;
                end
                else
                begin
                    col_next = CA_W'(col_inc);
                end
            end
            else
            begin
                row_next = RA_W'(row_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            below_reg    <= '0;
            next_num_reg <= NUM_FIRST;
            rows_lim_reg <= ROWS_RST;
            cols_lim_reg <= COLS_RST;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            below_reg    <= below_next;
            next_num_reg <= next_num_next;
            rows_lim_reg <= rows_lim_next;
            cols_lim_reg <= cols_lim_next;
        end
    end

    a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(row_reg) < rows_lim_reg)
        else $error("row index beyond frame height");

    a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        LIM_W'(col_reg) < cols_lim_reg)
        else $error("column index beyond frame width");

    a_num_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && point_valid |-> item.num != '0)
        else $error("valid pixel numbered zero");

endmodule

/* rtl/core/gmt_emit.sv */
// ----------------------------------------------------------------------------
// gmt_emit
// Holds one pixel after the line store read and emits its vertex and face
// records one per cycle through the output register while out_stall is low.
// ----------------------------------------------------------------------------
module gmt_emit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  gmt_pkg::scan_item_t          item,
    input  logic [gmt_pkg::NUM_W-1:0]    rd_data,
    output logic                         hold,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         record_kind,
    output logic [gmt_pkg::NUM_W-1:0]    first_vertex,
    output logic [gmt_pkg::NUM_W-1:0]    second_vertex,
    output logic [gmt_pkg::NUM_W-1:0]    third_vertex,
    output logic                         last
);
    import gmt_pkg::*;

    scan_item_t       s1_item_reg;
    logic             s1_valid_reg, s1_valid_next;
    rec_mask_t        done_reg,     done_next;
    logic [NUM_W-1:0] left_reg;

    logic             out_valid_reg, out_valid_next;
    record_kind_t     kind_reg,      kind_next;
    logic [NUM_W-1:0] first_reg,     first_next;
    logic [NUM_W-1:0] second_reg,    second_next;
    logic [NUM_W-1:0] third_reg,     third_next;
    logic             last_reg,      last_next;

    rec_mask_t present;
    rec_mask_t pend;
    rec_mask_t sel;
    rec_mask_t rest;
    logic      slot_free;
    logic      emit;
    logic      s1_free;
    logic      left_ok;

    always_comb
    begin
        left_ok             = (left_reg != '0);
        present[REC_VERTEX] = (s1_item_reg.num != '0);
        present[REC_FACE_A] = s1_item_reg.col_pos && present[REC_VERTEX] &&
                              s1_item_reg.has_up && left_ok && (rd_data != '0);
        present[REC_FACE_B] = s1_item_reg.col_pos && present[REC_VERTEX] &&
                              s1_item_reg.row_pos && left_ok &&
                              (s1_item_reg.below != '0);

        pend      = s1_valid_reg ? (present & ~done_reg) : '0;
        sel       = pend & (~pend + 1'b1);
        rest      = pend & ~sel;
        slot_free = !out_valid_reg || !out_stall;
        emit      = (pend != '0) && slot_free;
        s1_free   = s1_valid_reg && ((pend == '0) || (slot_free && (rest == '0)));
        hold      = s1_valid_reg && !s1_free;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        third_next     = third_reg;
        last_next      = last_reg;

        if (slot_free)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            last_next      = (rest == '0);
            done_next      = done_reg | sel;
            if (sel[REC_VERTEX])
            begin
                kind_next   = KIND_VERTEX;
                first_next  = s1_item_reg.num;
                second_next = '0;
                third_next  = '0;
            end
            else if (sel[REC_FACE_A])
            begin
                kind_next   = KIND_FACE;
                first_next  = left_reg;
                second_next = s1_item_reg.num;
                third_next  = rd_data;
            end
            else
            begin
                kind_next   = KIND_FACE;
                first_next  = left_reg;
                second_next = s1_item_reg.below;
                third_next  = s1_item_reg.num;
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
            done_next     = '0;
        end
        else if (s1_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
            // Upper neighbour of the previous pixel is this pixel's left neighbour
            left_reg    <= rd_data;
        end
        kind_reg   <= kind_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        last_reg   <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = kind_reg;
    assign first_vertex  = first_reg;
    assign second_vertex = second_reg;
    assign third_vertex  = third_reg;
    assign last          = last_reg;

    a_face_corners: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_FACE) |->
        (first_reg != '0) && (second_reg != '0) && (third_reg != '0))
        else $error("face record with an empty corner");

    a_vertex_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_VERTEX) |->
        (first_reg != '0) && (second_reg == '0) && (third_reg == '0))
        else $error("malformed vertex record");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (done_reg & ~present) == '0)
        else $error("record marked sent that the pixel does not have");

endmodule
